/* rtl/bdq_pkg.sv */
package bdq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_REVERSE    = 3'd4,
		OP_CLEAR      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int WORD_W = 32;

	// store access decided for one request
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} ring_ctl_t;

endpackage

/* rtl/bounded_deque.sv */
// channel   dir  handshake          tdata                         tuser
// s_*       in   s_tvalid/s_tready  value[31:0]                   op[2:0]
// m_*       out  m_tvalid/m_tready  popped_value, item_total      status[1:0]
//
// One request per cycle unless stalled; the result follows in the next cycle.
// Pop data comes from the word store's registered read port, issued at accept.
// Pointers and count update at accept, so a following request sees them at once.
// The result register holds while m_tready is low; s_tready follows it.
// Reset clears pointers, count and direction; store contents stay undefined.
module bounded_deque #(
	parameter int DEPTH = 64,
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW  = $clog2(DEPTH + 1),
	localparam int MDW = ((bdq_pkg::WORD_W + CW + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [bdq_pkg::WORD_W-1:0] s_tdata,  // value
	input  logic [2:0]                s_tuser,  // op
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [MDW-1:0]            m_tdata,  // popped_value, item_total, zero pad
	output logic [1:0]                m_tuser   // status
);

	logic                       accept;
	logic [AW-1:0]              addr;
	bdq_pkg::ring_ctl_t         ctl;
	logic [CW-1:0]              count_next;

	logic [bdq_pkg::WORD_W-1:0] mem [DEPTH];
	logic [bdq_pkg::WORD_W-1:0] rd_data_s1;
	logic                       valid_s1;
	logic                       pop_s1;
	bdq_pkg::status_t           status_s1;
	logic [CW-1:0]              count_s1;

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	bdq_ring #(.DEPTH(DEPTH)) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (s_tuser),
		.addr       (addr),
		.ctl        (ctl),
		.count_next (count_next)
	);

	// a request either writes or reads, never both, so no same-entry collision
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= s_tdata;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1    <= ctl.rd_en;
			status_s1 <= ctl.status;
			count_s1  <= count_next;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[bdq_pkg::WORD_W-1:0] = pop_s1 ? rd_data_s1 : '0;
		m_tdata[bdq_pkg::WORD_W +: CW] = count_s1;
	end

	assign m_tvalid = valid_s1;
	assign m_tuser  = status_s1;

endmodule

/* rtl/bdq_ring.sv */
module bdq_ring #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [2:0]          op,
	output logic [AW-1:0]       addr,
	output bdq_pkg::ring_ctl_t  ctl,
	output logic [CW-1:0]       count_next
);

	localparam int SW = AW + 1;

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic          rev_q, rev_d;

	logic          full, empty;
	logic [AW-1:0] front_dec, front_inc;
	logic [SW-1:0] back_sum, back_last;
	logic [AW-1:0] back_slot, last_slot;
	logic          push_at_front, pop_at_front;
	bdq_pkg::op_t  op_c;

	assign op_c  = bdq_pkg::op_t'(op);
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// front + count stays below 2*DEPTH, so one conditional subtract wraps it
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_last = back_sum - SW'(1);
	assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	assign last_slot = (back_last >= SW'(DEPTH)) ? AW'(back_last - SW'(DEPTH)) : AW'(back_last);

	assign push_at_front = (op_c == bdq_pkg::OP_PUSH_FRONT) ^ rev_q;
	assign pop_at_front  = (op_c == bdq_pkg::OP_POP_FRONT) ^ rev_q;

	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		rev_d      = rev_q;
		addr       = front_q;
		ctl.wr_en  = 1'b0;
		ctl.rd_en  = 1'b0;
		ctl.status = bdq_pkg::ST_OK;
		unique case (op_c)
			bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					ctl.status = bdq_pkg::ST_FULL;
				end else begin
					ctl.wr_en = accept;
					count_d   = count_q + CW'(1);
					if (push_at_front) begin
						front_d = front_dec;
						addr    = front_dec;
					end else begin
						addr = back_slot;
					end
				end
			end
			bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
				if (empty) begin
					ctl.status = bdq_pkg::ST_EMPTY;
				end else begin
					ctl.rd_en = accept;
					count_d   = count_q - CW'(1);
					if (pop_at_front) begin
						addr    = front_q;
						front_d = front_inc;
					end else begin
						addr = last_slot;
					end
				end
			end
			bdq_pkg::OP_REVERSE: begin
				rev_d = ~rev_q;
			end
			bdq_pkg::OP_CLEAR: begin
				front_d = '0;
				count_d = '0;
				rev_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign count_next = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

endmodule

/* rtl/bdq_checker.sv */
module bdq_checker #(
	parameter int DEPTH = 64,
	localparam int CW  = $clog2(DEPTH + 1),
	localparam int MDW = ((bdq_pkg::WORD_W + CW + 7) / 8) * 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [MDW-1:0]             m_tdata,
	input logic [1:0]                 m_tuser
);

	logic [CW-1:0] total;
	assign total = m_tdata[bdq_pkg::WORD_W +: CW];

	// every accepted request yields a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> total <= CW'(DEPTH))
		else $error("item_total above DEPTH");

	// a failed pop only happens on an empty deque and returns a zero word
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == bdq_pkg::ST_EMPTY |->
			total == '0 && m_tdata[bdq_pkg::WORD_W-1:0] == '0)
		else $error("empty status with nonzero count or data");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == bdq_pkg::ST_FULL |-> total == CW'(DEPTH))
		else $error("full status while not full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind bounded_deque bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
